[src/gae_pkg.sv]
package gae_pkg;

	localparam int TRIG_STAGES = 16;
	localparam int NUM_CELLS = (TRIG_STAGES < 24) ? TRIG_STAGES : 24;

	localparam logic [24:0] ANG_FULL = 25'd23592960;
	localparam logic [22:0] ANG_QUAD = 23'd5898240;
	localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;
	localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

	typedef struct packed {
		logic signed [31:0] angle_deg;
		logic signed [23:0] box_left;
		logic signed [23:0] box_top;
		logic [22:0] box_width;
		logic [22:0] box_height;
	} gae_in_t;

	typedef struct packed {
		logic signed [23:0] start_x;
		logic signed [23:0] start_y;
		logic signed [23:0] end_x;
		logic signed [23:0] end_y;
	} gae_out_t;

	// per-item data carried alongside the rotation
	typedef struct packed {
		logic signed [23:0] box_left;
		logic signed [23:0] box_top;
		logic [22:0] box_width;
		logic [22:0] box_height;
		logic [1:0] quad;
		logic axis;
	} gae_side_t;

	// one rotation cell state
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} gae_rot_t;

	function automatic logic signed [31:0] atan_q24(input logic [4:0] i);
		case (i)
			5'd0: atan_q24 = 32'sd754974720;
			5'd1: atan_q24 = 32'sd445687602;
			5'd2: atan_q24 = 32'sd235489088;
			5'd3: atan_q24 = 32'sd119537938;
			5'd4: atan_q24 = 32'sd60000934;
			5'd5: atan_q24 = 32'sd30029717;
			5'd6: atan_q24 = 32'sd15018523;
			5'd7: atan_q24 = 32'sd7509720;
			5'd8: atan_q24 = 32'sd3754917;
			5'd9: atan_q24 = 32'sd1877466;
			5'd10: atan_q24 = 32'sd938734;
			5'd11: atan_q24 = 32'sd469367;
			5'd12: atan_q24 = 32'sd234684;
			5'd13: atan_q24 = 32'sd117342;
			5'd14: atan_q24 = 32'sd58671;
			5'd15: atan_q24 = 32'sd29335;
			5'd16: atan_q24 = 32'sd14668;
			5'd17: atan_q24 = 32'sd7334;
			5'd18: atan_q24 = 32'sd3667;
			5'd19: atan_q24 = 32'sd1833;
			5'd20: atan_q24 = 32'sd917;
			5'd21: atan_q24 = 32'sd458;
			5'd22: atan_q24 = 32'sd229;
			5'd23: atan_q24 = 32'sd115;
			default: atan_q24 = 32'sd0;
		endcase
	endfunction

	// Q9 value to saturated Q8
	function automatic logic signed [23:0] to_q8(input logic signed [27:0] v9);
		logic signed [27:0] r;
		begin
			r = (v9 + 28'sd1) >>> 1;
			if (r > 28'sd8388607) to_q8 = 24'sh7FFFFF;
			else if (r < -28'sd8388608) to_q8 = 24'sh800000;
			else to_q8 = r[23:0];
		end
	endfunction

endpackage

[src/gradient_angle_endpoints_core.sv]
// Path from start to done: three wrap steps, NUM_CELLS rotation cells, then six
// projection steps.
// Throughput: one item per cycle; busy stays low, each cell step is one register.
// Reset: arst_n clears every valid flag; payload registers are not reset.
// done pulses for one cycle with the result; the receiver cannot stall.
module gradient_angle_endpoints_core
	import gae_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  gae_in_t in_item,
	output logic done,
	output gae_out_t out_item
);
	logic accept;
	assign busy = 1'b0;
	assign accept = start & ~busy;

	logic w_vld;
	gae_side_t w_side;
	logic [22:0] w_res;

	gae_wrap u_wrap (
		.clk(clk), .arst_n(arst_n), .in_vld(accept), .in_item(in_item),
		.out_vld(w_vld), .out_side(w_side), .out_res(w_res)
	);

	logic c_vld [0:NUM_CELLS];
	gae_rot_t c_rot [0:NUM_CELLS];
	gae_side_t c_side [0:NUM_CELLS];

	assign c_vld[0] = w_vld;
	assign c_side[0] = w_side;
	assign c_rot[0].x = GAIN_Q30;
	assign c_rot[0].y = '0;
	assign c_rot[0].z = {1'b0, w_res, 8'd0};

	for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
		gae_cell u_cell (
			.clk(clk), .arst_n(arst_n), .idx(5'(g)),
			.in_vld(c_vld[g]), .in_rot(c_rot[g]), .in_side(c_side[g]),
			.out_vld(c_vld[g+1]), .out_rot(c_rot[g+1]), .out_side(c_side[g+1])
		);
	end

	gae_proj u_proj (
		.clk(clk), .arst_n(arst_n), .in_vld(c_vld[NUM_CELLS]),
		.in_rot(c_rot[NUM_CELLS]), .in_side(c_side[NUM_CELLS]),
		.out_vld(done), .out_item(out_item)
	);
endmodule

[src/gae_wrap.sv]
// Angle wrap into quadrant and residual over three registered steps.
module gae_wrap
	import gae_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  gae_in_t in_item,
	output logic out_vld,
	output gae_side_t out_side,
	output logic [22:0] out_res
);
	// step 1: mod 360 via reciprocal multiply (|ang| <= 2^31, quotient < 92)
	logic [31:0] mag;
	logic [63:0] prod;
	logic [6:0] qt_s1;
	logic [31:0] mag_s1;
	logic neg_s1, vld_s1;
	gae_in_t it_s1;

	assign mag = in_item.angle_deg[31] ? 32'(-in_item.angle_deg) : in_item.angle_deg;
	// floor(2^37 / 23592960): the estimate is never high and at most one low
	assign prod = 64'(mag) * 64'd5825;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= in_vld;
	end
	always_ff @(posedge clk) begin
		qt_s1 <= prod[43:37];
		mag_s1 <= mag;
		neg_s1 <= in_item.angle_deg[31];
		it_s1 <= in_item;
	end

	// step 2: remainder and correction, then sign fold
	logic [31:0] rem0;
	logic [24:0] rem, m;
	logic [24:0] m_s2;
	logic vld_s2;
	gae_in_t it_s2;

	assign rem0 = mag_s1 - 32'(qt_s1) * 32'(ANG_FULL);
	always_comb begin
		if (rem0 >= 32'(ANG_FULL)) rem = 25'(rem0 - 32'(ANG_FULL));
		else rem = rem0[24:0];
		if (neg_s1 && rem != 25'd0) m = ANG_FULL - rem;
		else m = rem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else vld_s2 <= vld_s1;
	end
	always_ff @(posedge clk) begin
		m_s2 <= m;
		it_s2 <= it_s1;
	end

	// step 3: quadrant by compare
	logic [1:0] qd;
	logic [24:0] rr;
	always_comb begin
		if (m_s2 >= 25'(3 * ANG_QUAD)) begin
			qd = 2'd3; rr = m_s2 - 25'(3 * ANG_QUAD);
		end else if (m_s2 >= 25'(2 * ANG_QUAD)) begin
			qd = 2'd2; rr = m_s2 - 25'(2 * ANG_QUAD);
		end else if (m_s2 >= 25'(ANG_QUAD)) begin
			qd = 2'd1; rr = m_s2 - 25'(ANG_QUAD);
		end else begin
			qd = 2'd0; rr = m_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld <= 1'b0;
		else out_vld <= vld_s2;
	end
	always_ff @(posedge clk) begin
		out_res <= rr[22:0];
		out_side.box_left <= it_s2.box_left;
		out_side.box_top <= it_s2.box_top;
		out_side.box_width <= it_s2.box_width;
		out_side.box_height <= it_s2.box_height;
		out_side.quad <= qd;
		out_side.axis <= (rr == 25'd0);
	end
endmodule

[src/gae_cell.sv]
// One rotation step; hands its vector and side data to the next cell.
module gae_cell
	import gae_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic [4:0] idx,
	input  logic in_vld,
	input  gae_rot_t in_rot,
	input  gae_side_t in_side,
	output logic out_vld,
	output gae_rot_t out_rot,
	output gae_side_t out_side
);
	logic signed [31:0] dx, dy, at;
	assign dx = in_rot.y >>> idx;
	assign dy = in_rot.x >>> idx;
	assign at = atan_q24(idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld <= 1'b0;
		else out_vld <= in_vld;
	end
	always_ff @(posedge clk) begin
		out_side <= in_side;
		if (!in_rot.z[31]) begin
			out_rot.x <= in_rot.x - dx;
			out_rot.y <= in_rot.y + dy;
			out_rot.z <= in_rot.z - at;
		end else begin
			out_rot.x <= in_rot.x + dx;
			out_rot.y <= in_rot.y - dy;
			out_rot.z <= in_rot.z + at;
		end
	end
endmodule

[src/gae_proj.sv]
// Projection onto the gradient direction, mirror and offset.
module gae_proj
	import gae_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  gae_rot_t in_rot,
	input  gae_side_t in_side,
	output logic out_vld,
	output gae_out_t out_item
);
	// step 1: clamp and swap
	logic [30:0] sn, cs;
	always_comb begin
		if (in_rot.x < 0) cs = '0;
		else if (in_rot.x > ONE_Q30) cs = 31'(ONE_Q30);
		else cs = in_rot.x[30:0];
		if (in_rot.y < 0) sn = '0;
		else if (in_rot.y > ONE_Q30) sn = 31'(ONE_Q30);
		else sn = in_rot.y[30:0];
	end

	logic [30:0] sa_s1, ca_s1;
	logic vld_s1;
	gae_side_t sd_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= in_vld;
	end
	always_ff @(posedge clk) begin
		sd_s1 <= in_side;
		if (!in_side.quad[0]) begin
			sa_s1 <= sn; ca_s1 <= cs;
		end else begin
			sa_s1 <= cs; ca_s1 <= sn;
		end
	end

	// step 2: two products
	logic [53:0] pw_s2, ph_s2;
	logic [30:0] sa_s2, ca_s2;
	logic vld_s2;
	gae_side_t sd_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else vld_s2 <= vld_s1;
	end
	always_ff @(posedge clk) begin
		pw_s2 <= 54'(sd_s1.box_width) * 54'(sa_s1);
		ph_s2 <= 54'(sd_s1.box_height) * 54'(ca_s1);
		sa_s2 <= sa_s1;
		ca_s2 <= ca_s1;
		sd_s2 <= sd_s1;
	end

	// step 3: sum and shift
	logic [54:0] tsum;
	assign tsum = 55'(pw_s2) + 55'(ph_s2);
	logic [32:0] t_s3;
	logic [30:0] sa_s3, ca_s3;
	logic vld_s3;
	gae_side_t sd_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else vld_s3 <= vld_s2;
	end
	always_ff @(posedge clk) begin
		t_s3 <= tsum[54:22];
		sa_s3 <= sa_s2;
		ca_s3 <= ca_s2;
		sd_s3 <= sd_s2;
	end

	// step 4: second products, split into high and low halves of t
	logic [46:0] xh_s4, yh_s4, xl_s4, yl_s4;
	logic vld_s4;
	gae_side_t sd_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else vld_s4 <= vld_s3;
	end
	always_ff @(posedge clk) begin
		xh_s4 <= 47'(t_s3[32:17]) * 47'(sa_s3);
		yh_s4 <= 47'(t_s3[32:17]) * 47'(ca_s3);
		xl_s4 <= 47'(t_s3[16:0]) * 47'(sa_s3);
		yl_s4 <= 47'(t_s3[16:0]) * 47'(ca_s3);
		sd_s4 <= sd_s3;
	end

	// step 5: combine and round
	logic [64:0] px, py;
	assign px = (65'(xh_s4) << 17) + 65'(xl_s4) + (65'd1 << 37);
	assign py = (65'(yh_s4) << 17) + 65'(yl_s4) + (65'd1 << 37);
	logic [26:0] ex_s5, ey_s5;
	logic vld_s5;
	gae_side_t sd_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else vld_s5 <= vld_s4;
	end
	always_ff @(posedge clk) begin
		ex_s5 <= px[64:38];
		ey_s5 <= py[64:38];
		sd_s5 <= sd_s4;
	end

	// step 6: mirror, offset, saturate
	logic signed [27:0] l9, t9, w9, h9, sx, sy;
	logic signed [27:0] v0, v1, v2, v3;
	always_comb begin
		l9 = 28'(sd_s5.box_left) <<< 1;
		t9 = 28'(sd_s5.box_top) <<< 1;
		w9 = 28'(sd_s5.box_width);
		h9 = 28'(sd_s5.box_height);
		sx = (sd_s5.quad == 2'd0 || sd_s5.quad == 2'd1) ?
			28'(ex_s5) : -28'(ex_s5);
		sy = (sd_s5.quad == 2'd0 || sd_s5.quad == 2'd3) ?
			28'(ey_s5) : -28'(ey_s5);
		if (sd_s5.axis) begin
			v0 = l9; v1 = t9; v2 = l9; v3 = t9;
			case (sd_s5.quad)
				2'd0: v1 = t9 + (h9 <<< 1);
				2'd1: v2 = l9 + (w9 <<< 1);
				2'd2: v3 = t9 + (h9 <<< 1);
				default: v0 = l9 + (w9 <<< 1);
			endcase
		end else begin
			v0 = l9 + w9 - sx;
			v1 = t9 + h9 + sy;
			v2 = l9 + w9 + sx;
			v3 = t9 + h9 - sy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld <= 1'b0;
		else out_vld <= vld_s5;
	end
	always_ff @(posedge clk) begin
		out_item.start_x <= to_q8(v0);
		out_item.start_y <= to_q8(v1);
		out_item.end_x <= to_q8(v2);
		out_item.end_y <= to_q8(v3);
	end
endmodule
